// ===== rtl/otci_pkg.sv =====
// Shared types and constants for the order table with client id index.
`default_nettype none
package otci_pkg;

    localparam int ORDER_SLOTS = 64;
    localparam int SLOT_AW     = $clog2(ORDER_SLOTS);
    localparam int CNT_W       = SLOT_AW + 1;

    localparam logic [2:0] CMD_INSERT  = 3'd0;
    localparam logic [2:0] CMD_FIND    = 3'd1;
    localparam logic [2:0] CMD_FILL    = 3'd2;
    localparam logic [2:0] CMD_ERASE   = 3'd3;
    localparam logic [2:0] CMD_RESOLVE = 3'd4;
    localparam logic [2:0] CMD_LIST    = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_ZERO_QTY  = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL
    } t_state;

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] order_id;
        logic [15:0] session;
        logic [63:0] client_ref;
        logic [31:0] quantity;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] found_order_id;
        logic [15:0] entry_session;
        logic [63:0] entry_client_id;
        logic [31:0] remaining;
        logic        fully_filled;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [63:0] order_id;
        logic [15:0] session;
        logic [63:0] client_id;
        logic [31:0] remaining;
    } t_slot_ent;

    typedef struct packed {
        logic [15:0] session;
        logic [63:0] client_id;
        logic [63:0] order_id;
    } t_idx_ent;

    // Valid bit updates from the sequencer
    typedef struct packed {
        logic               slot_set;
        logic               slot_clr;
        logic [SLOT_AW-1:0] slot_sel;
        logic               idx_set;
        logic               idx_clr;
        logic [SLOT_AW-1:0] idx_sel;
    } t_vld_ctl;

    // Lowest free entries of both tables
    typedef struct packed {
        logic               slot_ok;
        logic [SLOT_AW-1:0] slot_sel;
        logic               idx_ok;
        logic [SLOT_AW-1:0] idx_sel;
    } t_free;

endpackage
`default_nettype wire

// ===== rtl/order_table_with_client_id_index_unit.sv =====
// Order table with client id index: top level.
// Each scan reads every entry of both tables, then decides; it is bound by the single
// read port of each table memory. Zero quantity insert or unknown command: no scan.
// Insert, find, resolve: one scan; fill or erase that removes: result after the first
// scan, next transfer after a second scan; list: one result per scan. Results never stall.
// Reset clears all valid bits at once; no clearing pass is needed.
`default_nettype none
module order_table_with_client_id_index_unit (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    output logic             busy,
    input  otci_pkg::t_cmd   i_cmd,
    output otci_pkg::t_res   o_res,
    output logic             o_res_strobe
);

    logic [otci_pkg::ORDER_SLOTS-1:0] slot_valid;
    logic [otci_pkg::ORDER_SLOTS-1:0] idx_valid;
    otci_pkg::t_free                  free;
    otci_pkg::t_vld_ctl               vld_ctl;
    logic [otci_pkg::SLOT_AW-1:0]     raddr;
    otci_pkg::t_slot_ent              slot_rd, slot_wd;
    otci_pkg::t_idx_ent               idx_rd, idx_wd;
    logic                             slot_we, idx_we;
    logic [otci_pkg::SLOT_AW-1:0]     slot_waddr, idx_waddr;

    otci_valid u_valid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (vld_ctl),
        .o_slot_valid (slot_valid),
        .o_idx_valid  (idx_valid),
        .o_free       (free)
    );

    otci_ram #(
        .WIDTH ($bits(otci_pkg::t_slot_ent)),
        .DEPTH (otci_pkg::ORDER_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wd),
        .i_raddr (raddr),
        .o_rdata (slot_rd)
    );

    otci_ram #(
        .WIDTH ($bits(otci_pkg::t_idx_ent)),
        .DEPTH (otci_pkg::ORDER_SLOTS)
    ) u_idx_ram (
        .i_clk   (i_clk),
        .i_we    (idx_we),
        .i_waddr (idx_waddr),
        .i_wdata (idx_wd),
        .i_raddr (raddr),
        .o_rdata (idx_rd)
    );

    otci_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .o_res        (o_res),
        .o_res_strobe (o_res_strobe),
        .i_slot_valid (slot_valid),
        .i_idx_valid  (idx_valid),
        .i_free       (free),
        .o_vld_ctl    (vld_ctl),
        .o_raddr      (raddr),
        .i_slot_rd    (slot_rd),
        .i_idx_rd     (idx_rd),
        .o_slot_we    (slot_we),
        .o_slot_waddr (slot_waddr),
        .o_slot_wd    (slot_wd),
        .o_idx_we     (idx_we),
        .o_idx_waddr  (idx_waddr),
        .o_idx_wd     (idx_wd)
    );

endmodule
`default_nettype wire

// ===== rtl/otci_ram.sv =====
// Generic simple dual port RAM with registered read.
`default_nettype none
module otci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/otci_valid.sv =====
// Valid bits of the order and index tables with lowest free entry search.
`default_nettype none
module otci_valid (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  otci_pkg::t_vld_ctl                   i_ctl,
    output logic [otci_pkg::ORDER_SLOTS-1:0]     o_slot_valid,
    output logic [otci_pkg::ORDER_SLOTS-1:0]     o_idx_valid,
    output otci_pkg::t_free                      o_free
);

    logic [otci_pkg::ORDER_SLOTS-1:0] r_slot_v;
    logic [otci_pkg::ORDER_SLOTS-1:0] r_idx_v;

    // Set and clear single bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_v <= '0;
            r_idx_v  <= '0;
        end else begin
            if (i_ctl.slot_set) r_slot_v[i_ctl.slot_sel] <= 1'b1;
            if (i_ctl.slot_clr) r_slot_v[i_ctl.slot_sel] <= 1'b0;
            if (i_ctl.idx_set)  r_idx_v[i_ctl.idx_sel]   <= 1'b1;
            if (i_ctl.idx_clr)  r_idx_v[i_ctl.idx_sel]   <= 1'b0;
        end
    end

    // Find lowest free entry of each table
    always_comb begin
        o_free = '0;
        for (int i = otci_pkg::ORDER_SLOTS - 1; i >= 0; i--) begin
            if (!r_slot_v[i]) begin
                o_free.slot_ok  = 1'b1;
                o_free.slot_sel = otci_pkg::SLOT_AW'(i);
            end
            if (!r_idx_v[i]) begin
                o_free.idx_ok  = 1'b1;
                o_free.idx_sel = otci_pkg::SLOT_AW'(i);
            end
        end
    end

    assign o_slot_valid = r_slot_v;
    assign o_idx_valid  = r_idx_v;

endmodule
`default_nettype wire

// ===== rtl/otci_ctrl.sv =====
// Command sequencer: scans both tables, modifies and writes back entries.
`default_nettype none
module otci_ctrl (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  otci_pkg::t_cmd                        i_cmd,
    output otci_pkg::t_res                        o_res,
    output logic                                  o_res_strobe,
    input  wire  [otci_pkg::ORDER_SLOTS-1:0]      i_slot_valid,
    input  wire  [otci_pkg::ORDER_SLOTS-1:0]      i_idx_valid,
    input  otci_pkg::t_free                       i_free,
    output otci_pkg::t_vld_ctl                    o_vld_ctl,
    output logic [otci_pkg::SLOT_AW-1:0]          o_raddr,
    input  otci_pkg::t_slot_ent                   i_slot_rd,
    input  otci_pkg::t_idx_ent                    i_idx_rd,
    output logic                                  o_slot_we,
    output logic [otci_pkg::SLOT_AW-1:0]          o_slot_waddr,
    output otci_pkg::t_slot_ent                   o_slot_wd,
    output logic                                  o_idx_we,
    output logic [otci_pkg::SLOT_AW-1:0]          o_idx_waddr,
    output otci_pkg::t_idx_ent                    o_idx_wd
);

    otci_pkg::t_state r_state, n_state;
    logic                          r_strobe, n_strobe;
    logic                          r_phase, n_phase;
    logic [otci_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    otci_pkg::t_cmd                r_cmd, n_cmd;
    otci_pkg::t_res                r_res, n_res;
    logic                          r_s_hit, n_s_hit;
    logic [otci_pkg::SLOT_AW-1:0]  r_s_idx, n_s_idx;
    otci_pkg::t_slot_ent           r_s_ent, n_s_ent;
    logic                          r_x_hit, n_x_hit;
    logic [otci_pkg::SLOT_AW-1:0]  r_x_idx, n_x_idx;
    logic [63:0]                   r_x_oid, n_x_oid;
    logic [15:0]                   r_key_sess, n_key_sess;
    logic [63:0]                   r_key_cid, n_key_cid;
    logic                          r_b_hit, n_b_hit;
    otci_pkg::t_slot_ent           r_b_ent, n_b_ent;
    logic [63:0]                   r_prev, n_prev;
    logic [otci_pkg::CNT_W-1:0]    r_n, n_n;
    logic [otci_pkg::CNT_W-1:0]    r_total, n_total;

    logic                          e_on;
    logic [otci_pkg::SLOT_AW-1:0]  e_addr;
    logic                          s_match, x_match, l_match;
    logic [31:0]                   fill_rem;
    logic                          ins_slot_ok, ins_idx_ok;
    logic [otci_pkg::SLOT_AW-1:0]  ins_slot, ins_idx;

    // Compare the entry read in the previous cycle
    always_comb begin
        e_addr  = otci_pkg::SLOT_AW'(r_cnt - otci_pkg::CNT_W'(1));
        e_on    = (r_state == otci_pkg::S_SCAN) && (r_cnt != '0);
        s_match = e_on && i_slot_valid[e_addr] && !r_s_hit
                  && (i_slot_rd.order_id == r_cmd.order_id);
        x_match = e_on && i_idx_valid[e_addr] && !r_x_hit
                  && (i_idx_rd.session == r_key_sess)
                  && (i_idx_rd.client_id == r_key_cid);
        l_match = e_on && i_slot_valid[e_addr]
                  && (i_slot_rd.session == r_cmd.session);
        fill_rem = (r_s_ent.remaining > r_cmd.quantity) ?
                   (r_s_ent.remaining - r_cmd.quantity) : 32'd0;
        ins_slot_ok = r_s_hit || i_free.slot_ok;
        ins_slot    = r_s_hit ? r_s_idx : i_free.slot_sel;
        ins_idx_ok  = r_x_hit || i_free.idx_ok;
        ins_idx     = r_x_hit ? r_x_idx : i_free.idx_sel;
    end

    // Next state and outputs
    always_comb begin
        n_state    = r_state;
        n_strobe   = 1'b0;
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_cmd      = r_cmd;
        n_res      = r_res;
        n_s_hit    = r_s_hit;
        n_s_idx    = r_s_idx;
        n_s_ent    = r_s_ent;
        n_x_hit    = r_x_hit;
        n_x_idx    = r_x_idx;
        n_x_oid    = r_x_oid;
        n_key_sess = r_key_sess;
        n_key_cid  = r_key_cid;
        n_b_hit    = r_b_hit;
        n_b_ent    = r_b_ent;
        n_prev     = r_prev;
        n_n        = r_n;
        n_total    = r_total;
        o_vld_ctl  = '0;
        o_slot_we  = 1'b0;
        o_slot_waddr = r_s_idx;
        o_slot_wd  = r_s_ent;
        o_idx_we   = 1'b0;
        o_idx_waddr = ins_idx;
        o_idx_wd   = '{session: r_cmd.session, client_id: r_cmd.client_ref,
                       order_id: r_cmd.order_id};

        unique case (r_state)
            otci_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd      = i_cmd;
                    n_cnt      = '0;
                    n_phase    = 1'b0;
                    n_s_hit    = 1'b0;
                    n_x_hit    = 1'b0;
                    n_b_hit    = 1'b0;
                    n_n        = '0;
                    n_total    = '0;
                    n_key_sess = i_cmd.session;
                    n_key_cid  = i_cmd.client_ref;
                    n_res      = '0;
                    n_res.last = 1'b1;
                    case (i_cmd.command) inside
                        otci_pkg::CMD_INSERT: begin
                            if (i_cmd.quantity == '0) begin
                                n_res.status = otci_pkg::ST_ZERO_QTY;
                                n_strobe     = 1'b1;
                            end else begin
                                n_state = otci_pkg::S_SCAN;
                            end
                        end
                        otci_pkg::CMD_FIND, otci_pkg::CMD_FILL, otci_pkg::CMD_ERASE,
                        otci_pkg::CMD_RESOLVE, otci_pkg::CMD_LIST: begin
                            n_state = otci_pkg::S_SCAN;
                        end
                        default: begin
                            n_res.status = otci_pkg::ST_NOT_FOUND;
                            n_strobe     = 1'b1;
                        end
                    endcase
                end
            end

            otci_pkg::S_SCAN: begin
                // Capture first matches and the running list minimum
                if (s_match) begin
                    n_s_hit = 1'b1;
                    n_s_idx = e_addr;
                    n_s_ent = i_slot_rd;
                end
                if (x_match) begin
                    n_x_hit = 1'b1;
                    n_x_idx = e_addr;
                    n_x_oid = i_idx_rd.order_id;
                end
                if (l_match) begin
                    if (r_n == '0) begin
                        n_total = r_total + otci_pkg::CNT_W'(1);
                    end
                    if ((r_n == '0 || i_slot_rd.order_id > r_prev)
                        && (!r_b_hit || i_slot_rd.order_id < r_b_ent.order_id)) begin
                        n_b_hit = 1'b1;
                        n_b_ent = i_slot_rd;
                    end
                end
                if (r_cnt == otci_pkg::CNT_W'(otci_pkg::ORDER_SLOTS)) begin
                    n_state = otci_pkg::S_EVAL;
                end else begin
                    n_cnt = r_cnt + otci_pkg::CNT_W'(1);
                end
            end

            otci_pkg::S_EVAL: begin
                n_state = otci_pkg::S_IDLE;
                n_cnt   = '0;
                n_res   = '0;
                n_res.last = 1'b1;
                if (r_phase) begin
                    // Drop the removed order and its index key
                    o_vld_ctl.slot_clr = 1'b1;
                    o_vld_ctl.slot_sel = r_s_idx;
                    o_vld_ctl.idx_clr  = r_x_hit;
                    o_vld_ctl.idx_sel  = r_x_idx;
                    n_res = r_res;
                end else begin
                    n_strobe = 1'b1;
                    case (r_cmd.command) inside
                        otci_pkg::CMD_INSERT: begin
                            if (ins_slot_ok && ins_idx_ok) begin
                                n_res.status       = otci_pkg::ST_OK;
                                o_slot_we          = 1'b1;
                                o_slot_waddr       = ins_slot;
                                o_slot_wd          = '{order_id: r_cmd.order_id,
                                                       session: r_cmd.session,
                                                       client_id: r_cmd.client_ref,
                                                       remaining: r_cmd.quantity};
                                o_idx_we           = 1'b1;
                                o_vld_ctl.slot_set = 1'b1;
                                o_vld_ctl.slot_sel = ins_slot;
                                o_vld_ctl.idx_set  = 1'b1;
                                o_vld_ctl.idx_sel  = ins_idx;
                            end else begin
                                n_res.status = otci_pkg::ST_FULL;
                            end
                        end
                        otci_pkg::CMD_FIND, otci_pkg::CMD_FILL, otci_pkg::CMD_ERASE: begin
                            if (!r_s_hit) begin
                                n_res.status = otci_pkg::ST_NOT_FOUND;
                            end else begin
                                n_res.status          = otci_pkg::ST_OK;
                                n_res.found_order_id  = r_s_ent.order_id;
                                n_res.entry_session   = r_s_ent.session;
                                n_res.entry_client_id = r_s_ent.client_id;
                                n_res.remaining       = r_s_ent.remaining;
                                if (r_cmd.command == otci_pkg::CMD_FILL) begin
                                    n_res.remaining    = fill_rem;
                                    n_res.fully_filled = (fill_rem == '0);
                                    o_slot_we          = 1'b1;
                                    o_slot_wd.remaining = fill_rem;
                                end
                                // Removal needs a second scan of the index
                                if (r_cmd.command == otci_pkg::CMD_ERASE
                                    || (r_cmd.command == otci_pkg::CMD_FILL
                                        && fill_rem == '0)) begin
                                    n_state    = otci_pkg::S_SCAN;
                                    n_phase    = 1'b1;
                                    n_x_hit    = 1'b0;
                                    n_key_sess = r_s_ent.session;
                                    n_key_cid  = r_s_ent.client_id;
                                end
                            end
                        end
                        otci_pkg::CMD_RESOLVE: begin
                            if (r_x_hit) begin
                                n_res.status         = otci_pkg::ST_OK;
                                n_res.found_order_id = r_x_oid;
                            end else begin
                                n_res.status = otci_pkg::ST_NOT_FOUND;
                            end
                        end
                        otci_pkg::CMD_LIST: begin
                            if (!r_b_hit) begin
                                n_res.status = otci_pkg::ST_NOT_FOUND;
                            end else begin
                                n_res.status          = otci_pkg::ST_OK;
                                n_res.found_order_id  = r_b_ent.order_id;
                                n_res.entry_session   = r_b_ent.session;
                                n_res.entry_client_id = r_b_ent.client_id;
                                n_res.remaining       = r_b_ent.remaining;
                                n_res.last = (r_n + otci_pkg::CNT_W'(1) == r_total);
                                n_n     = r_n + otci_pkg::CNT_W'(1);
                                n_prev  = r_b_ent.order_id;
                                n_b_hit = 1'b0;
                                if (r_n + otci_pkg::CNT_W'(1) != r_total) begin
                                    n_state = otci_pkg::S_SCAN;
                                end
                            end
                        end
                        default: begin
                            n_res.status = otci_pkg::ST_NOT_FOUND;
                        end
                    endcase
                end
            end

            default: begin
                n_state = otci_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= otci_pkg::S_IDLE;
            r_strobe <= 1'b0;
            r_phase  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_res      <= n_res;
        r_s_hit    <= n_s_hit;
        r_s_idx    <= n_s_idx;
        r_s_ent    <= n_s_ent;
        r_x_hit    <= n_x_hit;
        r_x_idx    <= n_x_idx;
        r_x_oid    <= n_x_oid;
        r_key_sess <= n_key_sess;
        r_key_cid  <= n_key_cid;
        r_b_hit    <= n_b_hit;
        r_b_ent    <= n_b_ent;
        r_prev     <= n_prev;
        r_n        <= n_n;
        r_total    <= n_total;
    end

    assign busy         = (r_state != otci_pkg::S_IDLE);
    assign o_res        = r_res;
    assign o_res_strobe = r_strobe;
    assign o_raddr      = r_cnt[otci_pkg::SLOT_AW-1:0];

endmodule
`default_nettype wire
